/* sv/btpm_pkg.sv */
// shared types and constants of the binary trie prefix match block
package btpm_pkg;

    // field widths fixed by the interface
    localparam int ACT_W    = 2;
    localparam int ADDR_W   = 128;
    localparam int HALF_W   = 64;
    localparam int LEN_W    = 8;
    localparam int PEER_W   = 16;
    localparam int STAT_W   = 2;
    localparam int TOTAL_W  = 13;
    localparam int MAXB_W   = 8;

    localparam logic [MAXB_W-1:0] ADDR_LEN_RST = 8'd32;

    // operation codes
    localparam logic [ACT_W-1:0] OP_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [ACT_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [ACT_W-1:0] OP_CLEAR  = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_ARG  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_ENTRY = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_NODES = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [PEER_W-1:0]  match_peer;
        logic [TOTAL_W-1:0] entry_total;
    } t_result;

endpackage

/* sv/btpm_ram.sv */
// generic single write port ram with registered read
module btpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/btpm_ctrl.sv */
// trie walk sequencer: node reads, allocation and write back
module btpm_ctrl #(
    parameter int NODE_COUNT = 4096,
    parameter int PEER_BITS  = 16,
    parameter int ADDR_BITS  = 128,
    parameter int IDX_W      = $clog2(NODE_COUNT),
    parameter int NODE_W     = PEER_BITS + 2 * IDX_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [btpm_pkg::ACT_W-1:0]    i_action,
    input  logic [btpm_pkg::HALF_W-1:0]   i_address_high,
    input  logic [btpm_pkg::HALF_W-1:0]   i_address_low,
    input  logic [btpm_pkg::LEN_W-1:0]    i_prefix_length,
    input  logic [btpm_pkg::PEER_W-1:0]   i_peer_id,
    input  logic [btpm_pkg::MAXB_W-1:0]   i_addr_len,
    input  logic                          i_out_free,
    output logic                          o_busy,
    output logic                          o_done,
    output btpm_pkg::t_result             o_result,
    output logic                          o_mem_we,
    output logic [IDX_W-1:0]              o_mem_waddr,
    output logic [NODE_W-1:0]             o_mem_wdata,
    output logic [IDX_W-1:0]              o_mem_raddr,
    input  logic [NODE_W-1:0]             i_mem_rdata
);

    localparam int CNT_W = $clog2(NODE_COUNT + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_CREATE = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam logic [btpm_pkg::LEN_W-1:0] ADDR_LIM = btpm_pkg::LEN_W'(ADDR_BITS);

    logic [2:0]                     r_state, n_state;
    logic [btpm_pkg::ACT_W-1:0]     r_op, n_op;
    logic [btpm_pkg::ADDR_W-1:0]    r_addr, n_addr;
    logic [btpm_pkg::LEN_W-1:0]     r_len, n_len;
    logic [btpm_pkg::LEN_W-1:0]     r_lim, n_lim;
    logic [btpm_pkg::LEN_W-1:0]     r_idx, n_idx;
    logic [PEER_BITS-1:0]           r_peer, n_peer;
    logic [PEER_BITS-1:0]           r_best, n_best;
    logic [IDX_W-1:0]               r_node, n_node;
    logic [NODE_W-1:0]              r_cur, n_cur;
    logic [btpm_pkg::STAT_W-1:0]    r_status, n_status;
    logic [CNT_W-1:0]               r_used, n_used;
    logic [CNT_W-1:0]               r_entry, n_entry;

    logic [31:0]                    w_peer_ext;
    logic [31:0]                    w_best_ext;
    logic [31:0]                    w_entry_ext;
    logic                           w_bit;
    logic [PEER_BITS-1:0]           w_q_peer;
    logic [IDX_W-1:0]               w_q_child;
    logic [PEER_BITS-1:0]           w_cur_peer;
    logic [IDX_W-1:0]               w_new_idx;
    logic [btpm_pkg::LEN_W-1:0]     w_target;

    assign w_peer_ext  = 32'(i_peer_id);
    assign w_best_ext  = 32'(r_best);
    assign w_entry_ext = 32'(r_entry);
    assign w_bit       = r_addr[btpm_pkg::ADDR_W-1];
    assign w_q_peer    = i_mem_rdata[NODE_W-1 -: PEER_BITS];
    assign w_q_child   = w_bit ? i_mem_rdata[2*IDX_W-1 -: IDX_W] : i_mem_rdata[IDX_W-1:0];
    assign w_cur_peer  = r_cur[NODE_W-1 -: PEER_BITS];
    assign w_new_idx   = r_used[IDX_W-1:0];
    assign w_target    = (r_op == btpm_pkg::OP_LOOKUP) ? r_lim : r_len;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_addr      = r_addr;
        n_len       = r_len;
        n_lim       = r_lim;
        n_idx       = r_idx;
        n_peer      = r_peer;
        n_best      = r_best;
        n_node      = r_node;
        n_cur       = r_cur;
        n_status    = r_status;
        n_used      = r_used;
        n_entry     = r_entry;
        o_done      = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_node;
        o_mem_wdata = r_cur;
        o_mem_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op     = i_action;
                    n_addr   = {i_address_high, i_address_low};
                    n_len    = i_prefix_length;
                    n_lim    = (i_addr_len > ADDR_LIM) ? ADDR_LIM : i_addr_len;
                    n_peer   = w_peer_ext[PEER_BITS-1:0];
                    n_idx    = '0;
                    n_node   = '0;
                    n_best   = '0;
                    n_status = btpm_pkg::ST_OK;
                    n_state  = S_START;
                end
            end
            S_START: begin
                // root read is issued here, data arrives in the walk state
                o_mem_raddr = '0;
                unique case (r_op)
                    btpm_pkg::OP_INSERT: begin
                        if (r_peer == '0 || r_len > r_lim) begin
                            n_status = btpm_pkg::ST_BAD_ARG;
                            n_state  = S_DONE;
                        end else if (r_used == '0) begin
                            n_used  = CNT_W'(1);
                            n_node  = '0;
                            n_cur   = '0;
                            n_state = S_CREATE;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    btpm_pkg::OP_LOOKUP: begin
                        n_state = (r_used == '0) ? S_DONE : S_WALK;
                    end
                    btpm_pkg::OP_REMOVE: begin
                        if (r_len > r_lim) begin
                            n_status = btpm_pkg::ST_BAD_ARG;
                            n_state  = S_DONE;
                        end else if (r_used == '0) begin
                            n_status = btpm_pkg::ST_NO_ENTRY;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    default: begin
                        n_used  = '0;
                        n_entry = '0;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_WALK: begin
                // ram output holds node r_node
                if (r_op == btpm_pkg::OP_LOOKUP && w_q_peer != '0) begin
                    n_best = w_q_peer;
                end
                if (r_idx < w_target) begin
                    if (w_q_child != '0) begin
                        o_mem_raddr = w_q_child;
                        n_node      = w_q_child;
                        n_idx       = r_idx + 1'b1;
                        n_addr      = r_addr << 1;
                    end else begin
                        unique case (r_op)
                            btpm_pkg::OP_INSERT: begin
                                n_cur   = i_mem_rdata;
                                n_state = S_CREATE;
                            end
                            btpm_pkg::OP_REMOVE: begin
                                n_status = btpm_pkg::ST_NO_ENTRY;
                                n_state  = S_DONE;
                            end
                            default: begin
                                n_state = S_DONE;
                            end
                        endcase
                    end
                end else begin
                    n_state = S_DONE;
                    unique case (r_op)
                        btpm_pkg::OP_INSERT: begin
                            o_mem_we    = 1'b1;
                            o_mem_wdata = {r_peer, i_mem_rdata[2*IDX_W-1:0]};
                            if (w_q_peer == '0) begin
                                n_entry = r_entry + 1'b1;
                            end
                        end
                        btpm_pkg::OP_REMOVE: begin
                            if (w_q_peer == '0) begin
                                n_status = btpm_pkg::ST_NO_ENTRY;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_wdata = {{PEER_BITS{1'b0}}, i_mem_rdata[2*IDX_W-1:0]};
                                if (r_entry != '0) begin
                                    n_entry = r_entry - 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CREATE: begin
                // r_cur holds the contents of r_node and is written back in every create step
                o_mem_we = 1'b1;
                if (r_idx < r_len) begin
                    if (r_used >= CNT_W'(NODE_COUNT)) begin
                        n_status = btpm_pkg::ST_NO_NODES;
                        n_state  = S_DONE;
                    end else begin
                        if (w_bit) begin
                            o_mem_wdata = {r_cur[NODE_W-1:2*IDX_W], w_new_idx,
                                           r_cur[IDX_W-1:0]};
                        end else begin
                            o_mem_wdata = {r_cur[NODE_W-1:IDX_W], w_new_idx};
                        end
                        n_used = r_used + 1'b1;
                        n_node = w_new_idx;
                        n_cur  = '0;
                        n_idx  = r_idx + 1'b1;
                        n_addr = r_addr << 1;
                    end
                end else begin
                    o_mem_wdata = {r_peer, r_cur[2*IDX_W-1:0]};
                    if (w_cur_peer == '0) begin
                        n_entry = r_entry + 1'b1;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_entry <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_entry <= n_entry;
        end
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_len    <= n_len;
        r_lim    <= n_lim;
        r_idx    <= n_idx;
        r_peer   <= n_peer;
        r_best   <= n_best;
        r_node   <= n_node;
        r_cur    <= n_cur;
        r_status <= n_status;
    end

    assign o_busy               = (r_state != S_IDLE);
    assign o_result.status      = r_status;
    assign o_result.match_peer  = w_best_ext[btpm_pkg::PEER_W-1:0];
    assign o_result.entry_total = w_entry_ext[btpm_pkg::TOTAL_W-1:0];

endmodule

/* sv/binary_trie_prefix_match.sv */
// top level of the binary trie longest prefix match table
//
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+-----------------------------------------
// input    | in        | i_in_valid/o_in_stall  | action, address_high/low, prefix_length,
//          |           |                        | peer_id
// output   | out       | o_out_valid/i_out_stall| status, match_peer, entry_total
// config   | in        | i_cfg_valid/o_cfg_ready| address length
//
// one item at a time; insert, lookup and remove walk the trie with one node memory
// read per address bit (walk length is prefix length, or the address length clipped
// to 128 for lookup; a missing child ends it early); an insert that adds nodes below an
// existing root allocates and writes one new node per remaining bit, while clear and
// rejected items do no walk
// synchronous active low reset empties the table and sets the address length to 32
// a finished result sits in the output register; the next item is taken while
// it waits, and a second finished result holds the sequencer and the input stall
module binary_trie_prefix_match #(
    parameter int NODE_COUNT = 4096,
    parameter int PEER_BITS  = 16,
    parameter int ADDR_BITS  = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input transfers
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [btpm_pkg::ACT_W-1:0]      i_action,
    input  logic [btpm_pkg::HALF_W-1:0]     i_address_high,
    input  logic [btpm_pkg::HALF_W-1:0]     i_address_low,
    input  logic [btpm_pkg::LEN_W-1:0]      i_prefix_length,
    input  logic [btpm_pkg::PEER_W-1:0]     i_peer_id,
    // result transfers
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [btpm_pkg::STAT_W-1:0]     o_status,
    output logic [btpm_pkg::PEER_W-1:0]     o_match_peer,
    output logic [btpm_pkg::TOTAL_W-1:0]    o_entry_total,
    // address length register write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [btpm_pkg::MAXB_W-1:0]     i_cfg_data
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int NODE_W = PEER_BITS + 2 * IDX_W;

    logic [btpm_pkg::MAXB_W-1:0] r_addr_len;
    logic                        r_out_valid;
    btpm_pkg::t_result           r_out;

    logic                        w_busy;
    logic                        w_done;
    logic                        w_out_free;
    logic                        w_accept;
    btpm_pkg::t_result           w_result;

    logic                        w_mem_we;
    logic [IDX_W-1:0]            w_mem_waddr;
    logic [NODE_W-1:0]           w_mem_wdata;
    logic [IDX_W-1:0]            w_mem_raddr;
    logic [NODE_W-1:0]           w_mem_rdata;

    // the sequencer only takes a new item when it is idle
    assign o_in_stall  = w_busy;
    assign w_accept    = i_in_valid && !w_busy;
    // output slot is free when empty or being emptied this cycle
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // node memory: peer id and two child indices per node
    btpm_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    btpm_ctrl #(
        .NODE_COUNT (NODE_COUNT),
        .PEER_BITS  (PEER_BITS),
        .ADDR_BITS  (ADDR_BITS),
        .IDX_W      (IDX_W),
        .NODE_W     (NODE_W)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_accept),
        .i_action        (i_action),
        .i_address_high  (i_address_high),
        .i_address_low   (i_address_low),
        .i_prefix_length (i_prefix_length),
        .i_peer_id       (i_peer_id),
        .i_addr_len      (r_addr_len),
        .i_out_free      (w_out_free),
        .o_busy          (w_busy),
        .o_done          (w_done),
        .o_result        (w_result),
        .o_mem_we        (w_mem_we),
        .o_mem_waddr     (w_mem_waddr),
        .o_mem_wdata     (w_mem_wdata),
        .o_mem_raddr     (w_mem_raddr),
        .i_mem_rdata     (w_mem_rdata)
    );

    // config register and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_len  <= btpm_pkg::ADDR_LEN_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_addr_len <= i_cfg_data;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_match_peer  = r_out.match_peer;
    assign o_entry_total = r_out.entry_total;

endmodule
